// File: rtl/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg
// Types, codes and sizing shared by the topic ring queue block.
// ----------------------------------------------------------------------------
package trq_pkg;

  localparam int NUM_TOPICS  = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_SLOTS   = NUM_TOPICS * QUEUE_DEPTH;

  localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes of the configuration port
  localparam logic CFG_TOPICS_IN_USE = 1'b0;
  localparam logic CFG_MAX_AGE       = 1'b1;

  localparam logic [2:0]  TOPICS_RESET  = 3'd1;
  localparam logic [31:0] MAX_AGE_RESET = 32'd3;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_GET = 2'd1,
    OP_DEQ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_TOPIC = 3'd3,
    ST_NO_NEWER = 3'd4,
    ST_NO_AGED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  topic;
    logic [31:0] publisher_id;
    logic [31:0] payload_ref;
    logic [31:0] last_seen;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seq_out;
    logic [31:0] publisher_out;
    logic [31:0] payload_out;
    logic [31:0] stamp_out;
  } out_item_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [31:0] publisher;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic [2:0]  topics_in_use;
    logic [31:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// File: rtl/topic_ring_queue_with_aging_top.sv
// ----------------------------------------------------------------------------
// topic_ring_queue_with_aging_top
// Per-topic ring queues with global sequence numbers and age-gated dequeue.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. Enqueue, rejected operations and
// empty-ring results go from decode straight to the result, a dequeue first
// checks the age of the head entry, and a get reads at most as many ring
// entries as the fill count of the topic (at most QUEUE_DEPTH = 8):
// the get walks the ring through the single read port of the entry memory,
// one entry a cycle, and stops early at an exact sequence match. Results wait
// in an output register, so a new input transaction is accepted while the
// previous result is still held on the output.
module topic_ring_queue_with_aging_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output trq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  trq_pkg::cfg_t      cfg;
  trq_pkg::out_item_t res_data;
  trq_pkg::mem_req_t  mem_req;
  trq_pkg::entry_t    rd_data;
  logic               res_valid;
  logic               res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.topics_in_use <= trq_pkg::TOPICS_RESET;
      cfg.max_age       <= trq_pkg::MAX_AGE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        trq_pkg::CFG_TOPICS_IN_USE: cfg.topics_in_use <= cfg_data[2:0];
        trq_pkg::CFG_MAX_AGE:       cfg.max_age       <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register: refill when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  trq_entry_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/trq_entry_mem.sv
// ----------------------------------------------------------------------------
// trq_entry_mem
// Entry store for all topic rings: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trq_entry_mem (
  input  logic              clk,
  input  trq_pkg::mem_req_t req,
  output trq_pkg::entry_t   rd_data
);

  trq_pkg::entry_t mem [trq_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// File: rtl/trq_ctrl.sv
// ----------------------------------------------------------------------------
// trq_ctrl
// Per-topic ring pointers, sequence counter and the operation sequencer
// that reads, checks and writes the entry store.
// ----------------------------------------------------------------------------
module trq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trq_pkg::in_item_t  in_data,
  input  trq_pkg::cfg_t      cfg,
  output logic               res_valid,
  input  logic               res_ready,
  output trq_pkg::out_item_t res_data,
  output trq_pkg::mem_req_t  mem_req,
  input  trq_pkg::entry_t    rd_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_AGE    = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  function automatic logic [trq_pkg::PTR_W-1:0] wrap_ptr(
    input logic [trq_pkg::PTR_W-1:0] p
  );
    logic [trq_pkg::PTR_W:0] inc;
    inc = {1'b0, p} + 1'b1;
    return (32'(inc) >= trq_pkg::QUEUE_DEPTH) ? '0 : inc[trq_pkg::PTR_W-1:0];
  endfunction

  function automatic logic [trq_pkg::ADDR_W-1:0] slot_addr(
    input logic [1:0]                t,
    input logic [trq_pkg::PTR_W-1:0] p
  );
    return trq_pkg::ADDR_W'(int'(t) * trq_pkg::QUEUE_DEPTH + int'(p));
  endfunction

  state_t                      state, state_next;
  trq_pkg::in_item_t           item, item_next;
  logic [trq_pkg::PTR_W-1:0]   head [trq_pkg::NUM_TOPICS];
  logic [trq_pkg::PTR_W-1:0]   head_next [trq_pkg::NUM_TOPICS];
  logic [trq_pkg::PTR_W-1:0]   tail [trq_pkg::NUM_TOPICS];
  logic [trq_pkg::PTR_W-1:0]   tail_next [trq_pkg::NUM_TOPICS];
  logic [trq_pkg::FILL_W-1:0]  fill [trq_pkg::NUM_TOPICS];
  logic [trq_pkg::FILL_W-1:0]  fill_next [trq_pkg::NUM_TOPICS];
  logic [31:0]                 next_seq, next_seq_next;
  logic [trq_pkg::FILL_W-1:0]  scan_cnt, scan_cnt_next;
  logic [trq_pkg::PTR_W-1:0]   issue_pos, issue_pos_next;
  logic                        have_gt, have_gt_next;
  trq_pkg::entry_t             cand, cand_next;
  trq_pkg::out_item_t          res, res_next;

  logic                        topic_ok;
  logic                        op_ok;
  logic [trq_pkg::PTR_W-1:0]   cur_head;
  logic [trq_pkg::PTR_W-1:0]   cur_tail;
  logic [trq_pkg::FILL_W-1:0]  cur_fill;
  logic [32:0]                 target;
  logic [32:0]                 seq_ext;
  logic                        hit_eq;
  logic                        hit_gt;
  logic                        scan_last;
  logic [31:0]                 age;

  assign cur_head  = head[item.topic];
  assign cur_tail  = tail[item.topic];
  assign cur_fill  = fill[item.topic];
  assign topic_ok  = ({1'b0, item.topic} < cfg.topics_in_use) &&
                     (32'(item.topic) < trq_pkg::NUM_TOPICS);
  assign op_ok     = (item.operation == trq_pkg::OP_ENQ) ||
                     (item.operation == trq_pkg::OP_GET) ||
                     (item.operation == trq_pkg::OP_DEQ);
  assign target    = {1'b0, item.last_seen} + 33'd1;
  assign seq_ext   = {1'b0, rd_data.seq};
  assign hit_eq    = (seq_ext == target);
  assign hit_gt    = (seq_ext > target);
  assign scan_last = ((scan_cnt + 1'b1) == cur_fill);
  assign age       = item.now - rd_data.stamp;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign res_data  = res;

  always_comb begin
    state_next     = state;
    item_next      = item;
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    next_seq_next  = next_seq;
    scan_cnt_next  = scan_cnt;
    issue_pos_next = issue_pos;
    have_gt_next   = have_gt;
    cand_next      = cand;
    res_next       = res;

    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = slot_addr(item.topic, cur_tail);
    mem_req.wr_data = '{seq: next_seq, stamp: item.now,
                        publisher: item.publisher_id, payload: item.payload_ref};
    mem_req.rd_addr = slot_addr(item.topic, issue_pos);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next  = in_data;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_next   = '0;
        state_next = S_FINISH;
        if (!op_ok || !topic_ok) begin
          res_next.status = trq_pkg::ST_NO_TOPIC;
        end else if (item.operation == trq_pkg::OP_ENQ) begin
          if (32'(cur_fill) >= trq_pkg::QUEUE_DEPTH) begin
            res_next.status = trq_pkg::ST_FULL;
          end else begin
            mem_req.wr_en          = 1'b1;
            tail_next[item.topic]  = wrap_ptr(cur_tail);
            fill_next[item.topic]  = cur_fill + 1'b1;
            next_seq_next          = (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
            res_next.status        = trq_pkg::ST_OK;
            res_next.seq_out       = next_seq;
          end
        end else if (cur_fill == '0) begin
          res_next.status = trq_pkg::ST_EMPTY;
        end else begin
          mem_req.rd_addr = slot_addr(item.topic, cur_head);
          if (item.operation == trq_pkg::OP_DEQ) begin
            state_next = S_AGE;
          end else begin
            issue_pos_next = wrap_ptr(cur_head);
            scan_cnt_next  = '0;
            have_gt_next   = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end
      S_AGE: begin
        state_next = S_FINISH;
        if (age > cfg.max_age) begin
          head_next[item.topic] = wrap_ptr(cur_head);
          fill_next[item.topic] = cur_fill - 1'b1;
          res_next.status       = trq_pkg::ST_OK;
        end else begin
          res_next.status = trq_pkg::ST_NO_AGED;
        end
      end
      S_SCAN: begin
        // exact match wins; otherwise the first newer entry from the head
        if (hit_eq || (scan_last && !have_gt && hit_gt)) begin
          res_next   = '{status: trq_pkg::ST_OK, seq_out: rd_data.seq,
                         publisher_out: rd_data.publisher,
                         payload_out: rd_data.payload, stamp_out: rd_data.stamp};
          state_next = S_FINISH;
        end else if (scan_last) begin
          if (have_gt) begin
            res_next = '{status: trq_pkg::ST_OK, seq_out: cand.seq,
                         publisher_out: cand.publisher,
                         payload_out: cand.payload, stamp_out: cand.stamp};
          end else begin
            res_next.status = trq_pkg::ST_NO_NEWER;
          end
          state_next = S_FINISH;
        end else begin
          if (hit_gt && !have_gt) begin
            cand_next    = rd_data;
            have_gt_next = 1'b1;
          end
          scan_cnt_next  = scan_cnt + 1'b1;
          issue_pos_next = wrap_ptr(issue_pos);
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      next_seq <= 32'd1;
      for (int t = 0; t < trq_pkg::NUM_TOPICS; t++) begin
        head[t] <= '0;
        tail[t] <= '0;
        fill[t] <= '0;
      end
      scan_cnt  <= '0;
      issue_pos <= '0;
      have_gt   <= 1'b0;
    end else begin
      state     <= state_next;
      next_seq  <= next_seq_next;
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      scan_cnt  <= scan_cnt_next;
      issue_pos <= issue_pos_next;
      have_gt   <= have_gt_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    cand <= cand_next;
    res  <= res_next;
  end

endmodule

// File: rtl/trq_checker.sv
// ----------------------------------------------------------------------------
// trq_port_checks
// Port-level checks for the topic ring queue block, bound to the top level.
// ----------------------------------------------------------------------------
module trq_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input trq_pkg::out_item_t out_data
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= trq_pkg::ST_NO_AGED)
    else $error("status code out of range");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != trq_pkg::ST_OK |->
      out_data.seq_out == '0 && out_data.publisher_out == '0 &&
      out_data.payload_out == '0 && out_data.stamp_out == '0)
    else $error("failed transaction carries entry fields");

endmodule

bind topic_ring_queue_with_aging_top trq_port_checks u_trq_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/trq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trq_checker
// Watches the input, output and register channels of the topic ring queue,
// keeps its own copy of the rings and registers, predicts the response of
// every accepted transaction and compares it with the response that leaves
// the block, in order.
// ----------------------------------------------------------------------------
module trq_checker
  import trq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data,
  output int        errors,
  output int        outstanding
);

  logic [2:0]        topics_cfg;
  logic [31:0]       age_limit;
  entry_t            ring_mem  [NUM_SLOTS];
  logic [PTR_W-1:0]  ring_head [NUM_TOPICS];
  logic [PTR_W-1:0]  ring_tail [NUM_TOPICS];
  logic [FILL_W-1:0] ring_fill [NUM_TOPICS];
  logic [31:0]       seq_next;
  out_item_t         resp_due [$];
  int                reported;

  function automatic logic [PTR_W-1:0] ring_advance(input int p);
    return (p + 1 >= QUEUE_DEPTH) ? '0 : PTR_W'(p + 1);
  endfunction

  // Apply one transaction to the rings and return the response it causes.
  function automatic out_item_t queue_step(input in_item_t it);
    out_item_t   r;
    int          limit;
    int          t;
    int          base;
    int          pos;
    int          hit;
    int          idx;
    logic [32:0] target;
    r = '0;
    limit = (int'(topics_cfg) > NUM_TOPICS) ? NUM_TOPICS : int'(topics_cfg);
    t = int'(it.topic);
    if (it.operation > OP_DEQ || t >= limit) begin
      r.status = ST_NO_TOPIC;
      return r;
    end
    base = t * QUEUE_DEPTH;

    if (it.operation == OP_ENQ) begin
      if (int'(ring_fill[t]) >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      idx = base + int'(ring_tail[t]);
      ring_mem[idx].seq       = seq_next;
      ring_mem[idx].stamp     = it.now;
      ring_mem[idx].publisher = it.publisher_id;
      ring_mem[idx].payload   = it.payload_ref;
      ring_tail[t] = ring_advance(int'(ring_tail[t]));
      ring_fill[t] = ring_fill[t] + 1'b1;
      r.status  = ST_OK;
      r.seq_out = seq_next;
      // zero is never handed out
      seq_next = (seq_next == 32'hFFFF_FFFF) ? 32'd1 : seq_next + 32'd1;
      return r;
    end

    if (ring_fill[t] == '0) begin
      r.status = ST_EMPTY;
      return r;
    end

    if (it.operation == OP_GET) begin
      target = {1'b0, it.last_seen} + 33'd1;
      hit = -1;
      // exact match first, then the first entry above the target
      pos = int'(ring_head[t]);
      for (int i = 0; i < int'(ring_fill[t]); i++) begin
        if (hit < 0 && {1'b0, ring_mem[base + pos].seq} == target) hit = pos;
        pos = int'(ring_advance(pos));
      end
      pos = int'(ring_head[t]);
      for (int i = 0; i < int'(ring_fill[t]); i++) begin
        if (hit < 0 && {1'b0, ring_mem[base + pos].seq} > target) hit = pos;
        pos = int'(ring_advance(pos));
      end
      if (hit < 0) begin
        r.status = ST_NO_NEWER;
        return r;
      end
      idx = base + hit;
      r.status        = ST_OK;
      r.seq_out       = ring_mem[idx].seq;
      r.publisher_out = ring_mem[idx].publisher;
      r.payload_out   = ring_mem[idx].payload;
      r.stamp_out     = ring_mem[idx].stamp;
      return r;
    end

    idx = base + int'(ring_head[t]);
    if ((it.now - ring_mem[idx].stamp) > age_limit) begin
      ring_head[t] = ring_advance(int'(ring_head[t]));
      ring_fill[t] = ring_fill[t] - 1'b1;
      r.status = ST_OK;
    end else begin
      r.status = ST_NO_AGED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      topics_cfg = TOPICS_RESET;
      age_limit  = MAX_AGE_RESET;
      seq_next   = 32'd1;
      for (int t = 0; t < NUM_TOPICS; t++) begin
        ring_head[t] = '0;
        ring_tail[t] = '0;
        ring_fill[t] = '0;
      end
      resp_due.delete();
      errors   = 0;
      reported = 0;
    end else begin
      // responses always leave after their transaction is taken, so
      // retire the output side before taking in a new transaction
      if (out_valid && out_ready) begin
        if (resp_due.size() == 0) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("%t unexpected response: status %0d seq %h", $realtime,
                     out_data.status, out_data.seq_out);
          end
        end else begin
          want = resp_due.pop_front();
          if (out_data.status !== want.status || out_data.seq_out !== want.seq_out ||
              out_data.publisher_out !== want.publisher_out ||
              out_data.payload_out !== want.payload_out ||
              out_data.stamp_out !== want.stamp_out) begin
            errors++;
            if (reported < 10) begin
              reported++;
              $display("%t mismatch (expected/actual): status %0d/%0d seq %h/%h",
                       $realtime, want.status, out_data.status,
                       want.seq_out, out_data.seq_out);
              $display("  publisher %h/%h payload %h/%h stamp %h/%h",
                       want.publisher_out, out_data.publisher_out,
                       want.payload_out, out_data.payload_out,
                       want.stamp_out, out_data.stamp_out);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOPICS_IN_USE) topics_cfg = cfg_data[2:0];
        else age_limit = cfg_data;
      end
      if (in_valid && in_ready) resp_due.push_back(queue_step(in_data));
    end
    outstanding = resp_due.size();
  end

endmodule

// File: tb/sv/tb_topic_ring_queue_with_aging_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topic_ring_queue_with_aging_top
// Drives directed and random enqueue, get and dequeue transactions into the
// topic ring queue over several register settings and flow-control phases,
// including a long output hold-off; the checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module tb_topic_ring_queue_with_aging_top;
  import trq_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 16;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int          errors;
  int          outstanding;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_reqs;
  int          hold_done;
  int          hold_left;
  int          quiet_cycles;
  logic [31:0] now_tick;
  logic [31:0] enq_sent;
  logic [2:0]  topics_now;

  topic_ring_queue_with_aging_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_topic_ring_queue_with_aging_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input logic [1:0] tp,
                                         input logic [31:0] pub, input logic [31:0] pay,
                                         input logic [31:0] last, input logic [31:0] tnow);
    in_item_t it;
    it.operation    = op;
    it.topic        = tp;
    it.publisher_id = pub;
    it.payload_ref  = pay;
    it.last_seen    = last;
    it.now          = tnow;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    if (it.operation == OP_ENQ) enq_sent = enq_sent + 32'd1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every response is back and the block is quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(input logic [2:0] topics, input logic [31:0] age,
                           input int idle_pct, input int stall_pct);
    drain();
    write_reg(CFG_TOPICS_IN_USE, {29'd0, topics});
    write_reg(CFG_MAX_AGE, age);
    topics_now     = topics;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    now_tick       = $urandom();
  endtask

  // mostly legal traffic on live topics, a few unused codes and dead topics
  task automatic random_burst(input int count);
    in_item_t it;
    int       pick;
    int       span;
    span = (int'(topics_now) > NUM_TOPICS) ? NUM_TOPICS : int'(topics_now);
    if (span == 0) span = NUM_TOPICS;
    repeat (count) begin
      pick            = $urandom_range(0, 99);
      it.publisher_id = $urandom();
      it.payload_ref  = $urandom();
      it.topic        = 2'($urandom_range(0, span - 1));
      if ($urandom_range(0, 9) == 0) it.last_seen = $urandom();
      else it.last_seen = enq_sent - 32'($urandom_range(0, 12));
      now_tick = now_tick + 32'($urandom_range(0, 3));
      it.now   = now_tick;
      if (pick < 45) begin
        it.operation = OP_ENQ;
      end else if (pick < 70) begin
        it.operation = OP_GET;
      end else if (pick < 95) begin
        it.operation = OP_DEQ;
      end else begin
        it.operation = 2'($urandom_range(0, 3));
        it.topic     = 2'($urandom_range(0, 3));
      end
      send_item(it);
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_TOPICS_IN_USE;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    enq_sent       = '0;
    topics_now     = TOPICS_RESET;
    // start just below the wrap of the time counter
    now_tick       = 32'hFFFF_FFFC;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one topic, max age 3
    send_item(make_item(OP_DEQ, 2'd0, '0, '0, '0, now_tick));
    send_item(make_item(OP_GET, 2'd0, '0, '0, '0, now_tick));
    send_item(make_item(OP_ENQ, 2'd1, '1, '1, '0, now_tick));
    send_item(make_item(OP_UNUSED, 2'd0, '1, '1, '1, now_tick));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_item(make_item(OP_ENQ, 2'd0, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1,
                          '0, now_tick));
      now_tick = now_tick + 32'd1;
    end
    send_item(make_item(OP_ENQ, 2'd0, 32'h1234_5678, 32'h9ABC_DEF0, '0, now_tick));
    send_item(make_item(OP_GET, 2'd0, '0, '0, 32'd0, now_tick));
    send_item(make_item(OP_GET, 2'd0, '0, '0, 32'hFFFF_FFFF, now_tick));
    send_item(make_item(OP_GET, 2'd0, '0, '0, 32'hFFFF_FFFE, now_tick));
    send_item(make_item(OP_GET, 2'd0, '0, '0, 32'd5, now_tick));
    // head too young, then old enough across the time wrap
    send_item(make_item(OP_DEQ, 2'd0, '0, '0, '0, 32'hFFFF_FFFE));
    send_item(make_item(OP_DEQ, 2'd0, '0, '0, '0, 32'd3));
    // target gone: fall back to the first newer entry
    send_item(make_item(OP_GET, 2'd0, '0, '0, 32'd0, 32'd3));
    // time running backwards gives a huge age
    send_item(make_item(OP_DEQ, 2'd0, '0, '0, '0, 32'hFFFF_FFFC));

    set_phase(3'd4, 32'd0, 0, 0);
    send_item(make_item(OP_ENQ, 2'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, now_tick));
    send_item(make_item(OP_DEQ, 2'd3, '0, '0, '0, now_tick));
    send_item(make_item(OP_DEQ, 2'd3, '0, '0, '0, now_tick + 32'd1));
    send_item(make_item(OP_GET, 2'd2, '0, '0, '0, now_tick));

    set_phase(3'd4, 32'd2, 0, 0);
    random_burst(130);
    set_phase(3'd2, 32'd0, 75, 0);
    random_burst(130);
    set_phase(3'd4, 32'd5, 0, 75);
    // hold the output off so the block backs up into its input
    hold_reqs++;
    random_burst(130);
    set_phase(3'd7, 32'hFFFF_FFFF, 25, 25);
    random_burst(130);
    set_phase(3'd0, 32'd1, 25, 25);
    random_burst(20);
    set_phase(3'd3, 32'd1, 0, 0);
    random_burst(75);
    recv_stall_pct = 25;
    send_idle_pct  = 25;
    random_burst(75);

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("tb_topic_ring_queue_with_aging_top: done, clean");
    end else begin
      $display("tb_topic_ring_queue_with_aging_top: done, errors");
    end
    $finish;
  end

endmodule
